// ===== hw/rtl/shs_pkg.sv =====
`default_nettype none

package shs_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_LEN_DEF     = 64;
    localparam int GAP_DIVISOR_DEF = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/shs_in_if.sv =====
`default_nettype none

interface shs_in_if;
    import shs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_in;
    logic                     is_last;

    modport source (output valid, output value_in, output is_last, input ready);
    modport sink   (input valid, input value_in, input is_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/shs_out_if.sv =====
`default_nettype none

interface shs_out_if;
    import shs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic                     last_out;
    logic                     overflow;

    modport source (output valid, output value_out, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input value_out, input last_out, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/shs_div.sv =====
`default_nettype none

// Divide by a constant through a reciprocal multiply; the quotient is registered and ready in the cycle after start.
module shs_div #(
    parameter int W           = 7,
    parameter int GAP_DIVISOR = 3
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int SH = W + 4;
    localparam int MW = SH + 1;
    localparam logic [MW-1:0] RECIP_C = MW'(((1 << SH) + GAP_DIVISOR - 1) / GAP_DIVISOR);

    logic            done_reg;
    logic [W-1:0]    quot_reg;
    logic [W+MW-1:0] prod;

    assign prod = {{MW{1'b0}}, dividend} * {{W{1'b0}}, RECIP_C};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                quot_reg <= prod[SH +: W];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

`default_nettype wire

// ===== hw/rtl/shell_sort.sv =====
`default_nettype none

// channel   dir  payload                          accepted when
// samples   in   value_in[31:0] s, is_last        valid && ready
// sorted    out  value_out[31:0] s, last_out,     valid && ready
//                overflow
//
// Load: one item per cycle; ready drops on the item marked last.
// Sort: each pass starts with a gap division; every insertion key is read, then shifted
// down by the gap while a compare finds it smaller, and written back where it stops.
// Output: each result is read from the store and held until the sink is ready; stalls hold the result.
// Reset clears the count and overflow flag; the store is not cleared.
module shell_sort #(
    parameter int MAX_LEN     = shs_pkg::MAX_LEN_DEF,
    parameter int GAP_DIVISOR = shs_pkg::GAP_DIVISOR_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    shs_in_if.sink   samples,
    shs_out_if.source sorted
);
    import shs_pkg::*;

    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIVW = CW;

    localparam logic [CW-1:0] LEN_C = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [3:0] {
        S_LOAD, S_DIV_N, S_PASS, S_I_CHK, S_KEY, S_J_CHK, S_CMP,
        S_DIV_GAP, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic            ovf_reg;
    logic [CW-1:0]   gap_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic [DATA_W-1:0] key_reg;
    logic            out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic            out_last_reg;
    logic            out_ovf_reg;

    logic [DATA_W-1:0] mem [MAX_LEN];
    logic [DATA_W-1:0] rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic            div_start;
    logic [DIVW-1:0] div_dividend;
    logic            div_done;
    logic [DIVW-1:0] div_quot;
    logic [CW-1:0]   quot_c;
    logic [CW-1:0]   jmg;
    logic            key_less;
    logic            in_acc;

    shs_div #(
        .W           (DIVW),
        .GAP_DIVISOR (GAP_DIVISOR)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot_c   = div_quot[CW-1:0];
    assign jmg      = j_reg - gap_reg;
    assign key_less = $signed(key_reg) < $signed(rd_data_reg);
    assign in_acc   = samples.valid && samples.ready;

    assign samples.ready   = (state_reg == S_LOAD);
    assign sorted.valid    = out_valid_reg;
    assign sorted.value_out = out_value_reg;
    assign sorted.last_out = out_last_reg;
    assign sorted.overflow = out_ovf_reg;

    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = key_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        case (state_reg)
            S_LOAD:
            begin
                wr_en   = in_acc && (count_reg < LEN_C);
                wr_addr = count_reg[AW-1:0];
                wr_data = samples.value_in;
            end
            S_I_CHK:
            begin
                rd_en   = (i_reg < count_reg);
                rd_addr = i_reg[AW-1:0];
                if (!(i_reg < count_reg) && gap_reg > ONE_C)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIVW'(gap_reg);
                end
            end
            S_J_CHK:
            begin
                rd_en   = (j_reg >= gap_reg);
                rd_addr = jmg[AW-1:0];
                wr_en   = !(j_reg >= gap_reg);
                wr_addr = j_reg[AW-1:0];
            end
            S_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                wr_data = key_less ? rd_data_reg : key_reg;
            end
            S_OUT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_LOAD && in_acc && samples.is_last)
        begin
            div_start    = 1'b1;
            div_dividend = (count_reg < LEN_C) ? DIVW'(count_reg + ONE_C) : DIVW'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            gap_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (count_reg < LEN_C)
                        begin
                            count_reg <= count_reg + ONE_C;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (samples.is_last)
                        begin
                            state_reg <= S_DIV_N;
                        end
                    end
                end
                S_DIV_N:
                begin
                    if (div_done)
                    begin
                        gap_reg   <= quot_c + ONE_C;
                        state_reg <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    i_reg     <= gap_reg;
                    state_reg <= S_I_CHK;
                end
                S_I_CHK:
                begin
                    j_reg <= i_reg;
                    if (i_reg < count_reg)
                    begin
                        state_reg <= S_KEY;
                    end
                    else if (gap_reg > ONE_C)
                    begin
                        state_reg <= S_DIV_GAP;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                end
                S_KEY:
                begin
                    key_reg   <= rd_data_reg;
                    state_reg <= S_J_CHK;
                end
                S_J_CHK:
                begin
                    if (j_reg >= gap_reg)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        i_reg     <= i_reg + ONE_C;
                        state_reg <= S_I_CHK;
                    end
                end
                S_CMP:
                begin
                    if (key_less)
                    begin
                        j_reg     <= jmg;
                        state_reg <= S_J_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + ONE_C;
                        state_reg <= S_I_CHK;
                    end
                end
                S_DIV_GAP:
                begin
                    if (div_done)
                    begin
                        gap_reg   <= (quot_c == '0) ? ONE_C : quot_c;
                        state_reg <= S_PASS;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_value_reg <= rd_data_reg;
                    out_last_reg  <= (i_reg + ONE_C == count_reg);
                    out_ovf_reg   <= ovf_reg;
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (sorted.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + ONE_C;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== bench/shell_sort_test.sv =====
`timescale 1ns / 100ps

module shell_sort_test;
    import shs_pkg::*;

    localparam int MAX_LEN     = MAX_LEN_DEF;
    localparam int GAP_DIV     = GAP_DIVISOR_DEF;
    localparam int RAND_ITEMS  = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } sorted_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        logic [DATA_W-1:0] want_value;
    } stim_row_t;

    localparam int N_DIRECTED = 18;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff},
        '{32'h80000000, 1'b1, 1'b1, 32'h80000000},
        '{32'h00000000, 1'b1, 1'b1, 32'h00000000},
        '{32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
        // five items: gap 2 divides to zero, forced gap-1 pass
        '{32'h7fffffff, 1'b0, 1'b0, 32'h0},
        '{32'h80000000, 1'b0, 1'b0, 32'h0},
        '{32'h00000000, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 1'b0, 1'b0, 32'h0},
        '{32'h00000001, 1'b1, 1'b0, 32'h0},
        // equal values
        '{32'h00000005, 1'b0, 1'b0, 32'h0},
        '{32'h00000005, 1'b0, 1'b0, 32'h0},
        '{32'hfffffffb, 1'b0, 1'b0, 32'h0},
        '{32'h00000005, 1'b1, 1'b0, 32'h0},
        // reversed order, then a pair already in order
        '{32'h00000003, 1'b0, 1'b0, 32'h0},
        '{32'h00000002, 1'b0, 1'b0, 32'h0},
        '{32'h00000001, 1'b1, 1'b0, 32'h0},
        '{32'haaaaaaaa, 1'b0, 1'b0, 32'h0},
        '{32'h55555555, 1'b1, 1'b0, 32'h0}
    };

    logic clk;
    logic rst_n;

    shs_in_if  in_ch ();
    shs_out_if out_ch ();

    shell_sort uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(in_ch),
        .sorted (out_ch)
    );

    always #5 clk = ~clk;

    sorted_item_t             sorted_expect [$];
    logic signed [DATA_W-1:0] load_buf [MAX_LEN];
    int                       load_count;
    bit                       load_dropped;

    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    bit  hold_done;
    int  hold_count;
    int  err_count;
    int  quiet_cycles;
    int  items_in;
    int  results_out;
    int  sets_done;
    int  overflow_sets;
    int  biggest_set;

    function automatic void take_sample(logic signed [DATA_W-1:0] v, logic l, bit emit);
        logic signed [DATA_W-1:0] key;
        int gap;
        int i;
        int j;
        if (load_count < MAX_LEN)
        begin
            load_buf[load_count] = v;
            load_count++;
        end
        else
            load_dropped = 1'b1;
        if (!l)
            return;
        gap = load_count / GAP_DIV + 1;
        while (1)
        begin
            for (i = gap; i < load_count; i++)
            begin
                key = load_buf[i];
                j = i;
                while (j >= gap && key < load_buf[j - gap])
                begin
                    load_buf[j] = load_buf[j - gap];
                    j -= gap;
                end
                load_buf[j] = key;
            end
            if (gap <= 1)
                break;
            gap = gap / GAP_DIV;
            if (gap == 0)
                gap = 1;
        end
        if (emit)
            for (i = 0; i < load_count; i++)
                sorted_expect.push_back('{load_buf[i], i == load_count - 1, load_dropped});
        sets_done++;
        if (load_dropped)
            overflow_sets++;
        if (load_count > biggest_set)
            biggest_set = load_count;
        load_count   = 0;
        load_dropped = 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1, 2, 3: return DATA_W'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [DATA_W-1:0] v, input logic l, input bit emit);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= v;
        in_ch.is_last  <= l;
        do @(posedge clk); while (!in_ch.ready);
        take_sample(v, l, emit);
        items_in++;
        @(negedge clk);
    endtask

    // receiver side; the long hold counts only cycles with a result offered
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                if (out_ch.valid)
                    hold_count++;
                if (hold_count >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        sorted_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_out++;
            if (sorted_expect.size() == 0)
            begin
                $display("%0t: unexpected item value=%0d last=%0b overflow=%0b", $time,
                         $signed(out_ch.value_out), out_ch.last_out, out_ch.overflow);
                err_count++;
            end
            else
            begin
                want = sorted_expect.pop_front();
                if (out_ch.value_out !== want.value)
                begin
                    $display("%0t: value_out expected %0d actual %0d", $time,
                             $signed(want.value), $signed(out_ch.value_out));
                    err_count++;
                end
                if (out_ch.last_out !== want.last)
                begin
                    $display("%0t: last_out expected %0b actual %0b", $time,
                             want.last, out_ch.last_out);
                    err_count++;
                end
                if (out_ch.overflow !== want.ovf)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             want.ovf, out_ch.overflow);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int set_idx;
        int set_size;
        int rand_sent;
        int k;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value_in = '0;
        in_ch.is_last  = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        hold_count     = 0;
        err_count      = 0;
        quiet_cycles   = 0;
        items_in       = 0;
        results_out    = 0;
        sets_done      = 0;
        overflow_sets  = 0;
        biggest_set    = 0;
        load_count     = 0;
        load_dropped   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (DIRECTED[k].typed)
                sorted_expect.push_back('{DIRECTED[k].want_value, 1'b1, 1'b0});
            send_item(DIRECTED[k].value, DIRECTED[k].last, !DIRECTED[k].typed);
        end

        set_idx   = 0;
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            case (set_idx % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                3: begin idle_pct = 19; stall_pct = 19; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (set_idx == 1)
                set_size = MAX_LEN + $urandom_range(1, 4);
            else if (set_idx == 4)
                set_size = MAX_LEN;
            else
                case ($urandom_range(0, 19))
                    0:          set_size = $urandom_range(33, MAX_LEN + 3);
                    1, 2, 3, 4: set_size = $urandom_range(9, 32);
                    default:    set_size = $urandom_range(1, 8);
                endcase
            // long receiver hold while the next set is offered
            if (set_idx == 2)
                hold_req = 1'b1;
            for (k = 0; k < set_size; k++)
                send_item(pick_value(), k == set_size - 1, 1'b1);
            rand_sent += set_size;
            set_idx++;
        end
        in_ch.valid <= 1'b0;

        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Summary: %0d sets sorted from %0d items, %0d results checked",
                 sets_done, items_in, results_out);
        $display("Summary: largest set %0d, %0d sets with dropped items, %0d mismatches",
                 biggest_set, overflow_sets, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
